// ===== src/irbs_pkg.sv =====
// ----------------------------------------------------------------------------
// irbs_pkg
// Shared widths, register indexes and the configuration type of the
// infrared bit sampler decoder.
// ----------------------------------------------------------------------------
package irbs_pkg;

    // decoded word width
    localparam int CODE_WIDTH = 16;

    // register field widths
    localparam int TIMER_WIDTH = 8;
    localparam int COUNT_WIDTH = 8;
    localparam int FRAME_WIDTH = 5;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;

    // timer limits
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = 8'd255;
    localparam logic [TIMER_WIDTH-1:0] EARLY_EDGE_LIMIT = 8'd2;
    localparam logic [TIMER_WIDTH-1:0] WINDOW_MARGIN = 8'd2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_GAP = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIT_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_BITS = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EMPTY_CODE = 2'd3;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // register values seen by the decoder
    typedef struct packed {
        logic [TIMER_WIDTH-1:0] idle_gap;
        logic [TIMER_WIDTH-1:0] bit_period;
        logic [FRAME_WIDTH-1:0] frame_bits;
        logic [CODE_WIDTH-1:0]  empty_code;
    } irbs_cfg_t;

    // item strobes from the handshake to the decoder
    typedef struct packed {
        logic tick_en;
        logic read_en;
        logic sample;
    } irbs_ctrl_t;

endpackage

// ===== src/irbs_if.sv =====
// ----------------------------------------------------------------------------
// irbs channel interfaces
// Valid/ready channels for sample items, code items and register writes.
// ----------------------------------------------------------------------------
interface irbs_in_if
    import irbs_pkg::*;
;
    logic valid;
    logic ready;
    logic kind;
    logic pin_level;

    modport source (output valid, output kind, output pin_level, input ready);
    modport sink (input valid, input kind, input pin_level, output ready);
endinterface

interface irbs_out_if
    import irbs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CODE_WIDTH-1:0] code;

    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

interface irbs_cfg_if
    import irbs_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/irbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// irbs_cfg_regs
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
module irbs_cfg_regs
    import irbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output irbs_cfg_t        cfg
);

    irbs_cfg_t cfg_reg;
    irbs_cfg_t cfg_next;

    // decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_IDLE_GAP:   cfg_next.idle_gap = wr_data[TIMER_WIDTH-1:0];
                REG_BIT_PERIOD: cfg_next.bit_period = wr_data[TIMER_WIDTH-1:0];
                REG_FRAME_BITS: cfg_next.frame_bits = wr_data[FRAME_WIDTH-1:0];
                REG_EMPTY_CODE: cfg_next.empty_code = wr_data[CODE_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_gap   <= '0;
            cfg_reg.bit_period <= 8'd3;
            cfg_reg.frame_bits <= 5'd1;
            cfg_reg.empty_code <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/irbs_decoder.sv =====
// ----------------------------------------------------------------------------
// irbs_decoder
// Edge timer, bit window check, shift word and held code of the decoder.
// ----------------------------------------------------------------------------
module irbs_decoder
    import irbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  irbs_cfg_t             cfg,
    input  irbs_ctrl_t            ctrl,
    output logic [CODE_WIDTH-1:0] held_code
);

    logic [TIMER_WIDTH-1:0] edge_timer_reg, edge_timer_next;
    logic                   prev_sample_reg, prev_sample_next;
    logic [COUNT_WIDTH-1:0] received_bits_reg, received_bits_next;
    logic [CODE_WIDTH-1:0]  shift_word_reg, shift_word_next;
    logic [CODE_WIDTH-1:0]  held_code_reg, held_code_next;

    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] window_lo;
    logic [TIMER_WIDTH-1:0] window_hi;
    logic                   is_edge;

    // window bounds wrap in eight bits
    assign window_lo = cfg.bit_period - WINDOW_MARGIN;
    assign window_hi = cfg.bit_period + WINDOW_MARGIN;
    assign timer_inc = (edge_timer_reg == TIMER_MAX) ? edge_timer_reg
                                                     : edge_timer_reg + 8'd1;
    assign is_edge   = (ctrl.sample != prev_sample_reg);

    // per-item state update
    always_comb
    begin
        edge_timer_next    = edge_timer_reg;
        prev_sample_next   = prev_sample_reg;
        received_bits_next = received_bits_reg;
        shift_word_next    = shift_word_reg;
        held_code_next     = held_code_reg;
        if (ctrl.read_en)
        begin
            held_code_next = cfg.empty_code;
        end
        else if (ctrl.tick_en)
        begin
            edge_timer_next  = timer_inc;
            prev_sample_next = ctrl.sample;
            if (is_edge)
            begin
                if (timer_inc <= EARLY_EDGE_LIMIT)
                begin
                    // edge too soon drops the frame
                    received_bits_next = '0;
                end
                else if (received_bits_reg == '0)
                begin
                    // start edge
                    if (ctrl.sample && (timer_inc > cfg.idle_gap))
                    begin
                        shift_word_next    = CODE_WIDTH'(1);
                        received_bits_next = COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        shift_word_next = '0;
                    end
                    edge_timer_next = '0;
                end
                else if (timer_inc >= window_lo)
                begin
                    if (timer_inc <= window_hi)
                    begin
                        shift_word_next    = {shift_word_reg[CODE_WIDTH-2:0], ctrl.sample};
                        received_bits_next = received_bits_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        received_bits_next = '0;
                    end
                    edge_timer_next = '0;
                end
            end
            else if (timer_inc > window_hi)
            begin
                // quiet line ends the frame
                if (received_bits_reg == COUNT_WIDTH'(cfg.frame_bits))
                begin
                    held_code_next = shift_word_reg;
                end
                received_bits_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_timer_reg    <= '0;
            prev_sample_reg   <= 1'b0;
            received_bits_reg <= '0;
            shift_word_reg    <= '0;
            held_code_reg     <= '0;
        end
        else
        begin
            edge_timer_reg    <= edge_timer_next;
            prev_sample_reg   <= prev_sample_next;
            received_bits_reg <= received_bits_next;
            shift_word_reg    <= shift_word_next;
            held_code_reg     <= held_code_next;
        end
    end

    assign held_code = held_code_reg;

endmodule

// ===== src/ir_remote_bit_sampler_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_remote_bit_sampler_decoder
// Oversampled infrared remote frame decoder with a held-code read port.
// ----------------------------------------------------------------------------
// Usage:
//   samples: each item is either a sample tick (kind = 0) carrying the raw,
//            active-low receiver pin level, or a read (kind = 1).
//   codes:   one item per read, carrying the held code before the read;
//            the held code then takes the empty_code register value.
//   cfg:     register writes (0 idle_gap, 1 bit_period,
//            2 frame_bits, 3 empty_code), always ready; writes are registered.
// Throughput: one item per cycle unless codes stalls. A tick updates the
//   edge timer, shift word and bit count in the cycle it is accepted; a read
//   loads the code output register and its item is on codes the cycle after.
// Stall: while a code item waits on codes and codes.ready is low, samples
//   is held off; ticks and reads flow freely as soon as it is taken.
// Reset: bit_period to 3, frame_bits to 1, other registers, the timer,
//   counters and held code to zero, and the code output register empties.
// ----------------------------------------------------------------------------
module ir_remote_bit_sampler_decoder
    import irbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    irbs_in_if.sink  samples,
    irbs_out_if.source codes,
    irbs_cfg_if.sink cfg
);

    irbs_cfg_t             cfg_vals;
    irbs_ctrl_t            ctrl;
    logic [CODE_WIDTH-1:0] held_code;
    logic                  in_fire;
    logic                  out_valid_reg, out_valid_next;
    logic [CODE_WIDTH-1:0] out_code_reg, out_code_next;

    // register file
    assign cfg.ready = 1'b1;

    irbs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_vals)
    );

    // input handshake
    assign samples.ready = !out_valid_reg || codes.ready;
    assign in_fire       = samples.valid && samples.ready;
    assign ctrl.tick_en  = in_fire && (samples.kind == KIND_TICK);
    assign ctrl.read_en  = in_fire && (samples.kind == KIND_READ);
    assign ctrl.sample   = ~samples.pin_level;

    irbs_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_vals),
        .ctrl      (ctrl),
        .held_code (held_code)
    );

    // code output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.read_en)
        begin
            out_valid_next = 1'b1;
            out_code_next  = held_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
    end

    assign codes.valid = out_valid_reg;
    assign codes.code  = out_code_reg;

`ifndef SYNTHESIS
    // an accepted read shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.read_en |=> codes.valid)
        else $error("read item not presented on codes");

    // an accepted read returns the code held before it
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.read_en |=> (codes.code == $past(held_code)))
        else $error("returned code differs from held code");

    // the held code takes the empty value after a read
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.read_en |=> (held_code == $past(cfg_vals.empty_code)))
        else $error("held code not replaced after read");

    // an empty output stage never blocks input items
    assert property (@(posedge clk) disable iff (!rst_n)
        !codes.valid |-> samples.ready)
        else $error("input stalled with empty output stage");
`endif

endmodule
